/* src/tmbc_pkg.sv */
// Package with the constants, types and helper functions of the tile map box collision block.
`default_nettype none

package tmbc_pkg;

  localparam int MAP_SIZE    = 16;
  localparam int TILE_PIXELS = 8;
  localparam int MAX_HITS    = 63;

  localparam int IDX_W   = $clog2(MAP_SIZE);
  localparam int PX_W    = 8;
  localparam int COUNT_W = 9;
  localparam int PROD_W  = IDX_W + 6;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CHECK = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } state_e;

  typedef struct packed {
    logic [1:0]      action;
    logic [3:0]      tile_col;
    logic [3:0]      tile_row;
    logic            write_value;
    logic [PX_W-1:0] box_left;
    logic [PX_W-1:0] box_right;
    logic [PX_W-1:0] box_top;
    logic [PX_W-1:0] box_bottom;
  } req_t;

  typedef struct packed {
    logic               read_value;
    logic               hit_valid;
    logic [PX_W-1:0]    hit_left;
    logic [PX_W-1:0]    hit_right;
    logic [PX_W-1:0]    hit_top;
    logic [PX_W-1:0]    hit_bottom;
    logic [COUNT_W-1:0] hit_count;
    logic               hit_overflow;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit_hit;
    logic emit_final;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
    logic under_max;
    logic at_end;
    logic out_free;
  } ctrl_sts_t;

  // Pixel edge of a tile boundary, saturated at the largest pixel value.
  function automatic logic [PX_W-1:0] tile_edge_px(input logic [IDX_W:0] tile);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(tile) * PROD_W'(TILE_PIXELS);
    if (prod > PROD_W'(255)) begin
      return PX_W'(255);
    end
    return prod[PX_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/tmbc_req_if.sv */
// Request channel interface of the tile map box collision block.
`default_nettype none

interface tmbc_req_if;
  logic          valid;
  logic          ready;
  tmbc_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/tmbc_rsp_if.sv */
// Response channel interface of the tile map box collision block.
`default_nettype none

interface tmbc_rsp_if;
  logic          valid;
  logic          ready;
  tmbc_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/tmbc_ctrl.sv */
// Controller state machine that sequences request intake, the tile scan and the final response.
`default_nettype none

module tmbc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_valid_i,
  input  wire logic [1:0]          req_action_i,
  input  wire tmbc_pkg::ctrl_sts_t sts_i,
  output tmbc_pkg::ctrl_cmd_t      cmd_o,
  output logic                     req_ready_o
);
  import tmbc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (req_action_i == ACT_CHECK) ? ST_SCAN : ST_FINAL;
        end
      end
      ST_SCAN: begin
        if (sts_i.empty) begin
          state_d = ST_FINAL;
        end else if (!(sts_i.hit && sts_i.under_max && !sts_i.out_free)) begin
          cmd_o.step     = 1'b1;
          cmd_o.emit_hit = sts_i.hit && sts_i.under_max;
          if (sts_i.at_end) begin
            state_d = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_final = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/tmbc_datapath.sv */
// Datapath with the tile map, the scan counters, the hit counter and the response register.
`default_nettype none

module tmbc_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tmbc_pkg::ctrl_cmd_t cmd_i,
  input  wire tmbc_pkg::req_t      req_data_i,
  output tmbc_pkg::ctrl_sts_t      sts_o,
  input  wire logic                rsp_ready_i,
  output logic                     rsp_valid_o,
  output tmbc_pkg::rsp_t           rsp_data_o
);
  import tmbc_pkg::*;

  logic [MAP_SIZE-1:0] rows_q [MAP_SIZE];
  logic [IDX_W-1:0]    x_q, y_q, tt_q, tb_q, tr_q;
  logic                empty_q;
  logic                rd_q;
  logic [COUNT_W-1:0]  count_q;
  logic                rsp_valid_q;
  rsp_t                rsp_data_q;

  logic [PX_W-1:0]  tl_full, tr_full, tt_full, tb_full;
  logic [IDX_W-1:0] tr_clamp, tb_clamp;
  logic             in_map;
  logic [IDX_W-1:0] col_idx, row_idx;
  logic [IDX_W-1:0] col_bit;
  logic             box_empty;
  rsp_t             hit_rsp, final_rsp;

  assign tl_full = PX_W'(req_data_i.box_left / TILE_PIXELS);
  assign tr_full = PX_W'(req_data_i.box_right / TILE_PIXELS);
  assign tt_full = PX_W'(req_data_i.box_top / TILE_PIXELS);
  assign tb_full = PX_W'(req_data_i.box_bottom / TILE_PIXELS);

  assign tr_clamp = (tr_full > PX_W'(MAP_SIZE - 1)) ? IDX_W'(MAP_SIZE - 1) : tr_full[IDX_W-1:0];
  assign tb_clamp = (tb_full > PX_W'(MAP_SIZE - 1)) ? IDX_W'(MAP_SIZE - 1) : tb_full[IDX_W-1:0];

  assign box_empty = (tl_full > PX_W'(tr_clamp)) || (tt_full > PX_W'(tb_clamp));

  assign in_map  = ({1'b0, req_data_i.tile_col} < 5'(MAP_SIZE)) &&
                   ({1'b0, req_data_i.tile_row} < 5'(MAP_SIZE));
  assign col_idx = req_data_i.tile_col[IDX_W-1:0];
  assign row_idx = req_data_i.tile_row[IDX_W-1:0];
  assign col_bit = IDX_W'(MAP_SIZE - 1) - col_idx;

  // Tile map, leftmost column in the most significant bit of each row word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAP_SIZE; r++) begin
        rows_q[r] <= '0;
      end
    end else if (cmd_i.load && req_data_i.action == ACT_WRITE && in_map) begin
      rows_q[row_idx][col_bit] <= req_data_i.write_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      empty_q <= 1'b0;
      rd_q    <= 1'b0;
    end else if (cmd_i.load) begin
      count_q <= '0;
      empty_q <= box_empty;
      rd_q    <= (req_data_i.action == ACT_READ) && in_map && rows_q[row_idx][col_bit];
    end else if (cmd_i.step) begin
      count_q <= count_q + COUNT_W'(sts_o.hit);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q  <= tl_full[IDX_W-1:0];
      y_q  <= tt_full[IDX_W-1:0];
      tt_q <= tt_full[IDX_W-1:0];
      tb_q <= tb_clamp;
      tr_q <= tr_clamp;
    end else if (cmd_i.step) begin
      if (y_q == tb_q) begin
        y_q <= tt_q;
        x_q <= x_q + IDX_W'(1);
      end else begin
        y_q <= y_q + IDX_W'(1);
      end
    end
  end

  assign sts_o.empty     = empty_q;
  assign sts_o.hit       = rows_q[y_q][IDX_W'(MAP_SIZE - 1) - x_q];
  assign sts_o.under_max = count_q < COUNT_W'(MAX_HITS);
  assign sts_o.at_end    = (x_q == tr_q) && (y_q == tb_q);
  assign sts_o.out_free  = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    hit_rsp            = '0;
    hit_rsp.hit_valid  = 1'b1;
    hit_rsp.hit_left   = tile_edge_px({1'b0, x_q});
    hit_rsp.hit_right  = tile_edge_px({1'b0, x_q} + (IDX_W + 1)'(1));
    hit_rsp.hit_top    = tile_edge_px({1'b0, y_q});
    hit_rsp.hit_bottom = tile_edge_px({1'b0, y_q} + (IDX_W + 1)'(1));

    final_rsp              = '0;
    final_rsp.read_value   = rd_q;
    final_rsp.hit_count    = count_q;
    final_rsp.hit_overflow = count_q > COUNT_W'(MAX_HITS);
    final_rsp.last         = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.emit_hit || cmd_i.emit_final) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_hit) begin
      rsp_data_q <= hit_rsp;
    end else if (cmd_i.emit_final) begin
      rsp_data_q <= final_rsp;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_data_o  = rsp_data_q;

endmodule

`default_nettype wire

/* src/tile_map_box_collision.sv */
// Top level of the tile map box collision block: controller, datapath and checks.
//
//   Channel  Direction  Carries
//   req_i    in         one request: write tile, read tile or check box
//   rsp_o    out        hit rectangles, then one final item marked last
//
// A write or read request passes through intake, then the final response.
// A box check scans one tile per cycle inside the box bounds while no hit waits on a stalled
// response register, then gives the final item; when the bounds hold no tile, none is scanned.
// Reset is asynchronous and clears the tile map at once; no clearing pass is needed.
// A stalled response register holds the scan only on a tile that is emitted as a hit,
// and holds the final item until the register can take it.
`default_nettype none

module tile_map_box_collision (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  tmbc_req_if.sink  req_i,
  tmbc_rsp_if.source rsp_o
);
  import tmbc_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  tmbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_action_i(req_i.data.action),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .req_ready_o (req_i.ready)
  );

  tmbc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_data_i (req_i.data),
    .sts_o      (sts),
    .rsp_ready_i(rsp_o.ready),
    .rsp_valid_o(rsp_o.valid),
    .rsp_data_o (rsp_o.data)
  );

  // Loading, emitting a hit and emitting the final item never happen together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.emit_hit, cmd.emit_final}))
    else $error("conflicting datapath commands");

  // A response is only written when the response register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_hit || cmd.emit_final) |-> sts.out_free)
    else $error("response written while the register is full");

  // A hit rectangle is only emitted while below the emission limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_hit |-> (sts.hit && sts.under_max))
    else $error("hit emitted beyond the limit or without a solid tile");

  // The overflow flag appears only on a final item whose count exceeds the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.data.hit_overflow) |->
      (rsp_o.data.last && rsp_o.data.hit_count > COUNT_W'(MAX_HITS)))
    else $error("overflow flag without an exceeded count");

endmodule

`default_nettype wire

/* tb/sv/tile_map_box_collision_test.sv */
// Self-checking testbench that drives tile writes, reads and box checks and compares every response.
`default_nettype none

module tile_map_box_collision_test;
  import tmbc_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int DENSE_TILES  = 72;

  logic clk = 1'b0;
  logic rst_n;

  tmbc_req_if req_ch ();
  tmbc_rsp_if rsp_ch ();

  tile_map_box_collision uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch.sink),
    .rsp_o  (rsp_ch.source)
  );

  logic [MAP_SIZE-1:0] tile_map [MAP_SIZE] = '{default: '0};
  rsp_t expected_rsps [$];
  rsp_t want;
  int   error_count    = 0;
  int   src_idle_pct   = 7;
  int   sink_stall_pct = 60;
  int   stalled_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [PX_W-1:0] pixel_edge(input int tile);
    int v;
    v = tile * TILE_PIXELS;
    return (v > 255) ? PX_W'(255) : PX_W'(v);
  endfunction

  // Updates the map copy and queues the responses that one request must produce.
  function automatic void predict_responses(input req_t r);
    rsp_t item;
    int   tl, tr, tt, tb, hits;
    bit   in_map;
    item = '0;
    if (r.action == ACT_CHECK) begin
      tl = r.box_left / TILE_PIXELS;
      tr = r.box_right / TILE_PIXELS;
      tt = r.box_top / TILE_PIXELS;
      tb = r.box_bottom / TILE_PIXELS;
      if (tr > MAP_SIZE - 1) tr = MAP_SIZE - 1;
      if (tb > MAP_SIZE - 1) tb = MAP_SIZE - 1;
      hits = 0;
      for (int x = tl; x <= tr; x++) begin
        for (int y = tt; y <= tb; y++) begin
          if (tile_map[y][MAP_SIZE-1-x]) begin
            if (hits < MAX_HITS) begin
              item = '0;
              item.hit_valid  = 1'b1;
              item.hit_left   = pixel_edge(x);
              item.hit_right  = pixel_edge(x + 1);
              item.hit_top    = pixel_edge(y);
              item.hit_bottom = pixel_edge(y + 1);
              expected_rsps.push_back(item);
            end
            hits++;
          end
        end
      end
      item = '0;
      item.hit_count    = COUNT_W'(hits);
      item.hit_overflow = (hits > MAX_HITS);
      item.last         = 1'b1;
      expected_rsps.push_back(item);
    end else begin
      item.last = 1'b1;
      in_map = (r.tile_col < MAP_SIZE) && (r.tile_row < MAP_SIZE);
      if (r.action == ACT_WRITE && in_map) begin
        tile_map[r.tile_row][MAP_SIZE-1-r.tile_col] = r.write_value;
      end else if (r.action == ACT_READ && in_map) begin
        item.read_value = tile_map[r.tile_row][MAP_SIZE-1-r.tile_col];
      end
      expected_rsps.push_back(item);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [COUNT_W-1:0] exp_val,
                                        input logic [COUNT_W-1:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got_val);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        predict_responses(req_ch.data);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response, expected none, got %p", $time, rsp_ch.data);
          error_count++;
        end else begin
          want = expected_rsps.pop_front();
          compare_field("read_value", COUNT_W'(want.read_value),
                        COUNT_W'(rsp_ch.data.read_value));
          compare_field("hit_valid", COUNT_W'(want.hit_valid),
                        COUNT_W'(rsp_ch.data.hit_valid));
          compare_field("hit_left", COUNT_W'(want.hit_left),
                        COUNT_W'(rsp_ch.data.hit_left));
          compare_field("hit_right", COUNT_W'(want.hit_right),
                        COUNT_W'(rsp_ch.data.hit_right));
          compare_field("hit_top", COUNT_W'(want.hit_top),
                        COUNT_W'(rsp_ch.data.hit_top));
          compare_field("hit_bottom", COUNT_W'(want.hit_bottom),
                        COUNT_W'(rsp_ch.data.hit_bottom));
          compare_field("hit_count", want.hit_count, rsp_ch.data.hit_count);
          compare_field("hit_overflow", COUNT_W'(want.hit_overflow),
                        COUNT_W'(rsp_ch.data.hit_overflow));
          compare_field("last", COUNT_W'(want.last), COUNT_W'(rsp_ch.data.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= IDLE_LIMIT) begin
      $display("tile_map_box_collision test failed");
      $finish;
    end
  end

  // Fields that the action does not use are filled with random values.
  function automatic req_t random_request();
    req_t r;
    r = '0;
    r.tile_col    = 4'($urandom);
    r.tile_row    = 4'($urandom);
    r.write_value = 1'($urandom);
    r.box_left    = PX_W'($urandom);
    r.box_right   = PX_W'($urandom);
    r.box_top     = PX_W'($urandom);
    r.box_bottom  = PX_W'($urandom);
    return r;
  endfunction

  task automatic send_request(input req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic send_tile_write(input int col, input int row, input logic value);
    req_t r;
    r = random_request();
    r.action      = ACT_WRITE;
    r.tile_col    = 4'(col);
    r.tile_row    = 4'(row);
    r.write_value = value;
    send_request(r);
  endtask

  task automatic send_tile_read(input int col, input int row);
    req_t r;
    r = random_request();
    r.action   = ACT_READ;
    r.tile_col = 4'(col);
    r.tile_row = 4'(row);
    send_request(r);
  endtask

  task automatic send_box_check(input int left, input int right, input int top, input int bottom);
    req_t r;
    r = random_request();
    r.action     = ACT_CHECK;
    r.box_left   = PX_W'(left);
    r.box_right  = PX_W'(right);
    r.box_top    = PX_W'(top);
    r.box_bottom = PX_W'(bottom);
    send_request(r);
  endtask

  task automatic test_tile_access();
    req_t r;
    send_tile_read(0, 0);
    send_tile_write(0, 0, 1'b1);
    send_tile_write(15, 0, 1'b1);
    send_tile_write(0, 15, 1'b1);
    send_tile_write(15, 15, 1'b1);
    send_tile_read(0, 0);
    send_tile_read(15, 15);
    send_tile_write(15, 15, 1'b0);
    send_tile_read(15, 15);
    r = random_request();
    r.action = ACT_UNUSED;
    send_request(r);
  endtask

  task automatic test_box_bounds();
    send_box_check(0, 255, 0, 255);
    send_box_check(0, 7, 0, 7);
    send_box_check(200, 100, 0, 255);
    send_box_check(0, 255, 255, 0);
    send_box_check(255, 255, 255, 255);
    send_box_check(120, 255, 120, 255);
    send_box_check(127, 127, 0, 7);
  endtask

  // Fills the map well past the emitted maximum, then checks large boxes.
  task automatic test_dense_map();
    int base, stride, idx, l, t;
    base   = $urandom_range(255);
    stride = 2 * $urandom_range(127) + 1;
    for (int i = 0; i < DENSE_TILES; i++) begin
      idx = (base + i * stride) % (MAP_SIZE * MAP_SIZE);
      send_tile_write(idx % MAP_SIZE, idx / MAP_SIZE, 1'b1);
    end
    send_box_check(0, 255, 0, 255);
    repeat (6) begin
      l = $urandom_range(64);
      t = $urandom_range(64);
      send_box_check(l, l + $urandom_range(63, 191), t, t + $urandom_range(63, 191));
    end
  endtask

  task automatic test_random_traffic(input int n);
    int kind, l, t, w, h;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        send_tile_write($urandom_range(15), $urandom_range(15), $urandom_range(99) < 55);
      end else if (kind < 55) begin
        send_tile_read($urandom_range(15), $urandom_range(15));
      end else if (kind < 93) begin
        l = $urandom_range(MAP_SIZE * TILE_PIXELS - 1);
        t = $urandom_range(MAP_SIZE * TILE_PIXELS - 1);
        if (kind < 85) begin
          w = $urandom_range(23);
          h = $urandom_range(23);
        end else begin
          w = $urandom_range(255 - l);
          h = $urandom_range(255 - t);
        end
        send_box_check(l, (l + w > 255) ? 255 : l + w, t, (t + h > 255) ? 255 : t + h);
      end else begin
        send_box_check($urandom_range(255), $urandom_range(255), $urandom_range(255),
                       $urandom_range(255));
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct   = 7;
    sink_stall_pct = 60;
    test_tile_access();
    test_box_bounds();
    test_random_traffic(40);

    src_idle_pct   = 60;
    sink_stall_pct = 7;
    test_dense_map();
    test_random_traffic(20);

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    test_random_traffic(35);

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("tile_map_box_collision test passed");
    end else begin
      $display("tile_map_box_collision test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
